/* design/sidc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_pkg
// Shared types and constants for the serial interface DMA controller.
// ----------------------------------------------------------------------------
package sidc_pkg;

  // item modes
  localparam logic [2:0] MODE_REG_RD = 3'd0;
  localparam logic [2:0] MODE_REG_WR = 3'd1;
  localparam logic [2:0] MODE_RAM_RD = 3'd2;
  localparam logic [2:0] MODE_RAM_WR = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  // register word indexes
  localparam logic [2:0] REG_MEM_ADDR = 3'd0;
  localparam logic [2:0] REG_RD_SRC   = 3'd1;
  localparam logic [2:0] REG_WR_SRC   = 3'd4;
  localparam logic [2:0] REG_STATUS   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_DMA_RD_TIME = 2'd0;
  localparam logic [1:0] CFG_DMA_WR_TIME = 2'd1;
  localparam logic [1:0] CFG_IO_WR_TIME  = 2'd2;

  // configuration reset values
  localparam logic [15:0] DMA_RD_TIME_RST = 16'd14000;
  localparam logic [15:0] DMA_WR_TIME_RST = 16'd4065;
  localparam logic [15:0] IO_WR_TIME_RST  = 16'd2150;

  // phase codes
  localparam logic [11:0] PHASE_PIF = 12'h9b0;
  localparam logic [11:0] PHASE_RD  = 12'h140;
  localparam logic [11:0] PHASE_WR  = 12'h410;

  // command area start inside the 2 KiB window
  localparam logic [10:0] CMD_AREA = 11'h7c0;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] ram_word;
    logic [31:0] tick_cycles;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        ram_write_go;
    logic        command_go;
    logic        io_finished;
    logic        dma_finished;
    logic        dma_toward_memory;
    logic [23:0] dma_memory_address;
    logic [31:0] dma_ram_address;
  } result_t;

endpackage

/* design/serial_interface_dma_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_interface_dma_controller
// Control part of an emulated serial interface: register and controller RAM
// accesses, time ticks, DMA and I/O countdowns, interrupt flag.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    mode, address, write_data,
//                                              ram_word, tick_cycles
//   out_     output     out_valid / out_stall  read_data, irq_level, events,
//                                              DMA address fields
//   cfg_     input      cfg_write_en           cfg_index, cfg_write_data
//
// One item per cycle sustained while out_stall stays low; each item passes
// the input register, then the result register, and its result is offered
// on out_ from the result register until it is taken.
// All item work is one pass of compares and 16-bit subtracts in sidc_ctrl.
// Synchronous active-low reset clears control state and loads the timing registers with their reset values.
// A stall on out_ holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
module serial_interface_dma_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_ram_word,
  input  logic [31:0] in_tick_cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_level,
  output logic        out_ram_write_go,
  output logic        out_command_go,
  output logic        out_io_finished,
  output logic        out_dma_finished,
  output logic        out_dma_toward_memory,
  output logic [23:0] out_dma_memory_address,
  output logic [31:0] out_dma_ram_address
);
  import sidc_pkg::*;

  item_t   in_item, s1_item;
  result_t ctrl_res, out_res;
  logic    s1_vld, out_ready, fire;

  assign in_item = '{mode:        in_mode,
                     address:     in_address,
                     write_data:  in_write_data,
                     ram_word:    in_ram_word,
                     tick_cycles: in_tick_cycles};

  // held item moves on when the result register has room
  assign fire = s1_vld && out_ready;

  sidc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (out_ready),
    .vld      (s1_vld),
    .item     (s1_item)
  );

  sidc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_write_data (cfg_write_data),
    .fire           (fire),
    .item           (s1_item),
    .res            (ctrl_res)
  );

  sidc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (ctrl_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields
  assign out_read_data          = out_res.read_data;
  assign out_irq_level          = out_res.irq_level;
  assign out_ram_write_go       = out_res.ram_write_go;
  assign out_command_go         = out_res.command_go;
  assign out_io_finished        = out_res.io_finished;
  assign out_dma_finished       = out_res.dma_finished;
  assign out_dma_toward_memory  = out_res.dma_toward_memory;
  assign out_dma_memory_address = out_res.dma_memory_address;
  assign out_dma_ram_address    = out_res.dma_ram_address;

endmodule

/* design/sidc_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_in_stage
// Input register: captures one item per transfer and holds it until the
// control stage takes it.
// ----------------------------------------------------------------------------
module sidc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sidc_pkg::item_t in_item,
  input  logic           take,
  output logic           vld,
  output sidc_pkg::item_t item
);
  import sidc_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  load;

  // stall only while a held item cannot move on
  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;

  assign vld_nxt = load ? 1'b1 : (take ? 1'b0 : vld_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

/* design/sidc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_ctrl
// Controller state: address registers, busy and phase bits, countdown
// timers, interrupt flag and timing registers. Works out one result per item.
// ----------------------------------------------------------------------------
module sidc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_write_en,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_write_data,
  input  logic             fire,
  input  sidc_pkg::item_t  item,
  output sidc_pkg::result_t res
);
  import sidc_pkg::*;

  // timing registers
  logic [15:0] dma_rd_time_r, dma_wr_time_r, io_wr_time_r;

  // controller state
  logic [23:0] mem_addr_r,   mem_addr_nxt;
  logic [31:0] rd_src_r,     rd_src_nxt;
  logic [31:0] wr_src_r,     wr_src_nxt;
  logic        dma_pend_r,   dma_pend_nxt;
  logic        dma_dir_r,    dma_dir_nxt;
  logic        dma_busy_r,   dma_busy_nxt;
  logic        io_busy_r,    io_busy_nxt;
  logic [11:0] phase_r,      phase_nxt;
  logic        irq_r,        irq_nxt;
  logic [15:0] dma_cnt_r,    dma_cnt_nxt;
  logic [15:0] io_cnt_r,     io_cnt_nxt;
  logic [31:0] io_latch_r,   io_latch_nxt;

  logic [2:0]  idx;
  logic        io_exp, dma_exp;
  logic [11:0] status_lo;

  assign idx = item.address[4:2];

  // timer expiry for a tick
  assign io_exp  = io_busy_r  && ({16'd0, io_cnt_r}  <= item.tick_cycles);
  assign dma_exp = dma_pend_r && ({16'd0, dma_cnt_r} <= item.tick_cycles);

  assign status_lo = phase_r | {10'd0, io_busy_r, dma_busy_r};

  // next state and result
  always_comb begin
    mem_addr_nxt = mem_addr_r;
    rd_src_nxt   = rd_src_r;
    wr_src_nxt   = wr_src_r;
    dma_pend_nxt = dma_pend_r;
    dma_dir_nxt  = dma_dir_r;
    dma_busy_nxt = dma_busy_r;
    io_busy_nxt  = io_busy_r;
    phase_nxt    = phase_r;
    irq_nxt      = irq_r;
    dma_cnt_nxt  = dma_cnt_r;
    io_cnt_nxt   = io_cnt_r;
    io_latch_nxt = io_latch_r;
    res          = '0;

    case (item.mode)
      MODE_REG_RD: begin
        case (idx)
          REG_MEM_ADDR: res.read_data = {8'd0, mem_addr_r};
          REG_RD_SRC:   res.read_data = rd_src_r;
          REG_WR_SRC:   res.read_data = wr_src_r;
          REG_STATUS:   res.read_data = {19'd0, irq_r, status_lo};
          default:      res.read_data = '0;
        endcase
      end
      MODE_REG_WR: begin
        case (idx)
          REG_MEM_ADDR: mem_addr_nxt = {item.write_data[23:3], 3'd0};
          REG_RD_SRC: begin
            rd_src_nxt   = {item.write_data[31:1], 1'b0};
            dma_dir_nxt  = 1'b1;
            dma_pend_nxt = 1'b1;
            dma_busy_nxt = 1'b1;
            phase_nxt    = PHASE_RD;
            dma_cnt_nxt  = dma_rd_time_r;
          end
          REG_WR_SRC: begin
            wr_src_nxt   = {item.write_data[31:1], 1'b0};
            dma_dir_nxt  = 1'b0;
            dma_pend_nxt = 1'b1;
            dma_busy_nxt = 1'b1;
            phase_nxt    = PHASE_WR;
            dma_cnt_nxt  = dma_wr_time_r;
          end
          REG_STATUS: irq_nxt = 1'b0;
          default: ;
        endcase
      end
      MODE_RAM_RD: begin
        if (io_busy_r) begin
          // read while a word write is in flight returns the latched word
          res.read_data = io_latch_r;
          io_busy_nxt   = 1'b0;
          io_cnt_nxt    = '0;
        end else begin
          res.read_data = item.ram_word;
        end
      end
      MODE_RAM_WR: begin
        if (!io_busy_r) begin
          io_busy_nxt      = 1'b1;
          dma_busy_nxt     = 1'b1;
          phase_nxt        = PHASE_PIF;
          io_latch_nxt     = item.write_data;
          io_cnt_nxt       = io_wr_time_r;
          res.ram_write_go = 1'b1;
          res.command_go   = (item.address[10:0] >= CMD_AREA);
        end
      end
      MODE_TICK: begin
        if (item.tick_cycles != '0) begin
          // saturating countdowns
          if (io_busy_r) begin
            io_cnt_nxt = io_exp ? 16'd0 : (io_cnt_r - item.tick_cycles[15:0]);
          end
          if (dma_pend_r) begin
            dma_cnt_nxt = dma_exp ? 16'd0 : (dma_cnt_r - item.tick_cycles[15:0]);
          end
          if (io_exp) begin
            io_busy_nxt     = 1'b0;
            dma_busy_nxt    = 1'b0;
            phase_nxt       = '0;
            irq_nxt         = 1'b1;
            res.io_finished = 1'b1;
          end
          if (dma_exp) begin
            res.dma_finished       = 1'b1;
            res.dma_toward_memory  = dma_dir_r;
            res.dma_memory_address = mem_addr_r;
            res.dma_ram_address    = dma_dir_r ? rd_src_r : wr_src_r;
            dma_pend_nxt           = 1'b0;
            dma_busy_nxt           = 1'b0;
            phase_nxt              = '0;
            irq_nxt                = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res.irq_level = irq_nxt;
  end

  // timing registers: the user writes them only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_rd_time_r <= DMA_RD_TIME_RST;
      dma_wr_time_r <= DMA_WR_TIME_RST;
      io_wr_time_r  <= IO_WR_TIME_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_DMA_RD_TIME: dma_rd_time_r <= cfg_write_data;
        CFG_DMA_WR_TIME: dma_wr_time_r <= cfg_write_data;
        CFG_IO_WR_TIME:  io_wr_time_r  <= cfg_write_data;
        default: ;
      endcase
    end
  end

  // state update on each transfer into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_addr_r <= '0;
      rd_src_r   <= '0;
      wr_src_r   <= '0;
      dma_pend_r <= 1'b0;
      dma_dir_r  <= 1'b0;
      dma_busy_r <= 1'b0;
      io_busy_r  <= 1'b0;
      phase_r    <= '0;
      irq_r      <= 1'b0;
      dma_cnt_r  <= '0;
      io_cnt_r   <= '0;
      io_latch_r <= '0;
    end else if (fire) begin
      mem_addr_r <= mem_addr_nxt;
      rd_src_r   <= rd_src_nxt;
      wr_src_r   <= wr_src_nxt;
      dma_pend_r <= dma_pend_nxt;
      dma_dir_r  <= dma_dir_nxt;
      dma_busy_r <= dma_busy_nxt;
      io_busy_r  <= io_busy_nxt;
      phase_r    <= phase_nxt;
      irq_r      <= irq_nxt;
      dma_cnt_r  <= dma_cnt_nxt;
      io_cnt_r   <= io_cnt_nxt;
      io_latch_r <= io_latch_nxt;
    end
  end

endmodule

/* design/sidc_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sidc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sidc_pkg::result_t res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output sidc_pkg::result_t out_res
);
  import sidc_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  // room when empty or when the held result leaves this cycle
  assign ready   = !vld_r || !out_stall;
  assign vld_nxt = fire ? 1'b1 : (out_stall ? vld_r : 1'b0);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

/* design/sidc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_checker
// Port-level checks for the serial interface DMA controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module sidc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data,
  input logic        out_irq_level,
  input logic        out_ram_write_go,
  input logic        out_command_go,
  input logic        out_io_finished,
  input logic        out_dma_finished,
  input logic        out_dma_toward_memory,
  input logic [23:0] out_dma_memory_address,
  input logic [31:0] out_dma_ram_address
);

  // a finished timer always raises the interrupt
  a_finish_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_io_finished || out_dma_finished) |-> out_irq_level)
    else $error("timer finished without interrupt");

  // command processing only follows an accepted RAM write
  a_cmd_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_go |-> out_ram_write_go)
    else $error("command without RAM write");

  // DMA fields are quiet unless a DMA finished
  a_dma_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dma_finished |->
      (out_dma_ram_address == 32'd0) && (out_dma_memory_address == 24'd0) &&
      !out_dma_toward_memory)
    else $error("DMA fields set without DMA finish");

  // memory address is 8-byte aligned
  a_dma_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dma_memory_address[2:0] == 3'd0))
    else $error("DMA memory address not aligned");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

endmodule

bind serial_interface_dma_controller sidc_checker u_sidc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_read_data          (out_read_data),
  .out_irq_level          (out_irq_level),
  .out_ram_write_go       (out_ram_write_go),
  .out_command_go         (out_command_go),
  .out_io_finished        (out_io_finished),
  .out_dma_finished       (out_dma_finished),
  .out_dma_toward_memory  (out_dma_toward_memory),
  .out_dma_memory_address (out_dma_memory_address),
  .out_dma_ram_address    (out_dma_ram_address)
);

/* tb/sv/serial_interface_dma_controller_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_interface_dma_controller_test
// Self-checking bench for the serial interface DMA controller. A short
// directed sequence walks the register map, the RAM accesses and the timer
// corner cases. Random traffic then runs under several timing settings,
// including all-zero and all-ones. A local model of the controller predicts
// every result, and each result is compared field by field. The sender
// idles in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module serial_interface_dma_controller_test;
  import sidc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  // modes the block does not decode
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic [31:0] in_ram_word = '0;
  logic [31:0] in_tick_cycles = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq_level;
  logic        out_ram_write_go;
  logic        out_command_go;
  logic        out_io_finished;
  logic        out_dma_finished;
  logic        out_dma_toward_memory;
  logic [23:0] out_dma_memory_address;
  logic [31:0] out_dma_ram_address;

  serial_interface_dma_controller u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_write_en           (cfg_write_en),
    .cfg_index              (cfg_index),
    .cfg_write_data         (cfg_write_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_mode                (in_mode),
    .in_address             (in_address),
    .in_write_data          (in_write_data),
    .in_ram_word            (in_ram_word),
    .in_tick_cycles         (in_tick_cycles),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_data          (out_read_data),
    .out_irq_level          (out_irq_level),
    .out_ram_write_go       (out_ram_write_go),
    .out_command_go         (out_command_go),
    .out_io_finished        (out_io_finished),
    .out_dma_finished       (out_dma_finished),
    .out_dma_toward_memory  (out_dma_toward_memory),
    .out_dma_memory_address (out_dma_memory_address),
    .out_dma_ram_address    (out_dma_ram_address)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // timing registers as the controller holds them
  logic [15:0] dma_rd_time_q = DMA_RD_TIME_RST;
  logic [15:0] dma_wr_time_q = DMA_WR_TIME_RST;
  logic [15:0] io_wr_time_q  = IO_WR_TIME_RST;

  // controller state mirror
  logic [23:0] mem_addr_q    = '0;
  logic [31:0] rd_src_q      = '0;
  logic [31:0] wr_src_q      = '0;
  logic        dma_pending_q = 1'b0;
  logic        dma_to_mem_q  = 1'b0;
  logic        dma_busy_q    = 1'b0;
  logic        io_busy_q     = 1'b0;
  logic [11:0] phase_q       = '0;
  logic        irq_q         = 1'b0;
  logic [15:0] dma_cnt_q     = '0;
  logic [15:0] io_cnt_q      = '0;
  logic [31:0] io_latch_q    = '0;

  item_t   bus_items[$];
  result_t ctrl_results_due[$];
  item_t   drv_item;
  result_t due_result;

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int err_count      = 0;
  int dma_done_count = 0;
  int io_done_count  = 0;
  int cmd_count      = 0;
  int settings_run   = 0;
  int cycle_count    = 0;
  int burst_left     = 8;
  int gap_left       = 0;
  bit drain_hold     = 1'b0;
  int stall_style    = 0;

  // advance the controller by one transfer and return its result
  function automatic result_t step_controller(input item_t it);
    result_t     r;
    logic [2:0]  word;
    logic        io_done;
    logic        dma_done;
    r        = '0;
    word     = it.address[4:2];
    io_done  = 1'b0;
    dma_done = 1'b0;
    case (it.mode)
      MODE_REG_RD: begin
        case (word)
          REG_MEM_ADDR: r.read_data = {8'd0, mem_addr_q};
          REG_RD_SRC:   r.read_data = rd_src_q;
          REG_WR_SRC:   r.read_data = wr_src_q;
          REG_STATUS:   r.read_data = {19'd0, irq_q, phase_q} | {30'd0, io_busy_q, dma_busy_q};
          default:      r.read_data = '0;
        endcase
      end
      MODE_REG_WR: begin
        case (word)
          REG_MEM_ADDR: mem_addr_q = {it.write_data[23:3], 3'b000};
          REG_RD_SRC, REG_WR_SRC: begin
            // either source register kicks off a DMA in its direction
            dma_to_mem_q = (word == REG_RD_SRC);
            if (dma_to_mem_q) rd_src_q = {it.write_data[31:1], 1'b0};
            else wr_src_q = {it.write_data[31:1], 1'b0};
            dma_pending_q = 1'b1;
            dma_busy_q    = 1'b1;
            phase_q       = dma_to_mem_q ? PHASE_RD : PHASE_WR;
            dma_cnt_q     = dma_to_mem_q ? dma_rd_time_q : dma_wr_time_q;
          end
          REG_STATUS: irq_q = 1'b0;
          default: ;
        endcase
      end
      MODE_RAM_RD: begin
        // a read during a pending write returns the latched word and cuts it short
        if (io_busy_q) begin
          r.read_data = io_latch_q;
          io_busy_q   = 1'b0;
          io_cnt_q    = '0;
        end else begin
          r.read_data = it.ram_word;
        end
      end
      MODE_RAM_WR: begin
        if (!io_busy_q) begin
          io_busy_q      = 1'b1;
          dma_busy_q     = 1'b1;
          phase_q        = PHASE_PIF;
          io_latch_q     = it.write_data;
          io_cnt_q       = io_wr_time_q;
          r.ram_write_go = 1'b1;
          r.command_go   = (it.address[10:0] >= CMD_AREA);
        end
      end
      MODE_TICK: begin
        if (it.tick_cycles != '0) begin
          // saturating countdowns, expiry when count fits in the tick
          if (io_busy_q) begin
            if ({16'd0, io_cnt_q} <= it.tick_cycles) begin
              io_cnt_q = '0;
              io_done  = 1'b1;
            end else begin
              io_cnt_q = io_cnt_q - it.tick_cycles[15:0];
            end
          end
          if (dma_pending_q) begin
            if ({16'd0, dma_cnt_q} <= it.tick_cycles) begin
              dma_cnt_q = '0;
              dma_done  = 1'b1;
            end else begin
              dma_cnt_q = dma_cnt_q - it.tick_cycles[15:0];
            end
          end
          if (io_done) begin
            io_busy_q       = 1'b0;
            dma_busy_q      = 1'b0;
            phase_q         = '0;
            irq_q           = 1'b1;
            r.io_finished   = 1'b1;
          end
          if (dma_done) begin
            r.dma_finished       = 1'b1;
            r.dma_toward_memory  = dma_to_mem_q;
            r.dma_memory_address = mem_addr_q;
            r.dma_ram_address    = dma_to_mem_q ? rd_src_q : wr_src_q;
            dma_pending_q        = 1'b0;
            dma_busy_q           = 1'b0;
            phase_q              = '0;
            irq_q                = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.irq_level = irq_q;
    return r;
  endfunction

  task automatic queue_item(input logic [2:0] mode, input logic [31:0] addr,
                            input logic [31:0] wdata, input logic [31:0] rword,
                            input logic [31:0] cyc);
    item_t it;
    it.mode        = mode;
    it.address     = addr;
    it.write_data  = wdata;
    it.ram_word    = rword;
    it.tick_cycles = cyc;
    bus_items.push_back(it);
    items_queued++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // block until every queued transfer has come back, then let the pipe settle
  task automatic wait_idle();
    while (items_accepted != items_queued || ctrl_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // program all three timing registers while the block is idle
  task automatic write_timing(input logic [15:0] rd, input logic [15:0] wr,
                              input logic [15:0] io);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_index      <= CFG_DMA_RD_TIME;
    cfg_write_data <= rd;
    @(posedge clk);
    cfg_index      <= CFG_DMA_WR_TIME;
    cfg_write_data <= wr;
    @(posedge clk);
    cfg_index      <= CFG_IO_WR_TIME;
    cfg_write_data <= io;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    dma_rd_time_q = rd;
    dma_wr_time_q = wr;
    io_wr_time_q  = io;
  endtask

  // random traffic, ticks scaled to the current timing so timers expire often
  task automatic queue_random_items(input int count);
    logic [31:0] addr;
    logic [31:0] cyc;
    logic [2:0]  mode;
    logic [2:0]  word;
    int          span;
    int          pick;
    span = dma_rd_time_q;
    if (dma_wr_time_q > span) span = dma_wr_time_q;
    if (io_wr_time_q > span) span = io_wr_time_q;
    span = span / 3 + 2;
    for (int n = 0; n < count; n++) begin
      addr = $urandom();
      cyc  = $urandom();
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1:    word = REG_MEM_ADDR;
        2, 3:    word = REG_RD_SRC;
        4, 5:    word = REG_WR_SRC;
        6, 7, 8: word = REG_STATUS;
        default: word = 3'($urandom());
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        mode = MODE_TICK;
        case ($urandom_range(0, 19))
          0:          cyc = '0;
          1, 2:       cyc = $urandom();
          3, 4, 5, 6: cyc = $urandom_range(1, 8);
          default:    cyc = $urandom_range(1, span);
        endcase
      end else if (pick < 43) begin
        mode = MODE_REG_WR;
        addr[4:2] = word;
      end else if (pick < 60) begin
        mode = MODE_REG_RD;
        addr[4:2] = word;
      end else if (pick < 77) begin
        mode = MODE_RAM_WR;
        if ($urandom_range(0, 2) == 0) addr[10:6] = 5'h1f;
      end else if (pick < 95) begin
        mode = MODE_RAM_RD;
      end else begin
        mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end
      queue_item(mode, addr, $urandom(), $urandom(), cyc);
    end
  endtask

  task automatic run_setting(input logic [15:0] rd, input logic [15:0] wr,
                             input logic [15:0] io, input int count);
    write_timing(rd, wr, io);
    queue_random_items(count);
    wait_idle();
    settings_run++;
  endtask

  // sender: bursts with random gaps, occasional hold until all results are back
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ctrl_results_due.push_back(step_controller(drv_item));
        items_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (drain_hold && ctrl_results_due.size() != 0) begin
          in_valid <= 1'b0;
        end else if (bus_items.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          drain_hold = 1'b0;
          drv_item = bus_items.pop_front();
          in_mode        <= drv_item.mode;
          in_address     <= drv_item.address;
          in_write_data  <= drv_item.write_data;
          in_ram_word    <= drv_item.ram_word;
          in_tick_cycles <= drv_item.tick_cycles;
          in_valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(10, 30);
            drain_hold = ($urandom_range(0, 9) == 0);
          end
        end
      end
    end
  end

  // receiver: checks each result against its prediction and stalls in a randomly chosen style
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (ctrl_results_due.size() == 0) begin
          $error("result transfer with no prediction pending");
          err_count++;
        end else begin
          due_result = ctrl_results_due.pop_front();
          check_field("read_data", due_result.read_data, out_read_data);
          check_field("irq_level", due_result.irq_level, out_irq_level);
          check_field("ram_write_go", due_result.ram_write_go, out_ram_write_go);
          check_field("command_go", due_result.command_go, out_command_go);
          check_field("io_finished", due_result.io_finished, out_io_finished);
          check_field("dma_finished", due_result.dma_finished, out_dma_finished);
          check_field("dma_toward_memory", due_result.dma_toward_memory,
                      out_dma_toward_memory);
          check_field("dma_memory_address", due_result.dma_memory_address,
                      out_dma_memory_address);
          check_field("dma_ram_address", due_result.dma_ram_address, out_dma_ram_address);
          dma_done_count += due_result.dma_finished;
          io_done_count  += due_result.io_finished;
          cmd_count      += due_result.command_go;
        end
      end
      if (cycle_count % 50 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 7) == 0);
        2:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ((cycle_count & 4) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk under the reset timing
    queue_item(MODE_REG_RD, 32'h0000_0018, '0, '0, '0);
    queue_item(MODE_REG_RD, 32'hffff_ffe8, '0, '0, '0);        // unmapped word reads zero
    queue_item(MODE_REG_WR, 32'hffff_ffe0, 32'hffff_ffff, '0, '0);
    queue_item(MODE_REG_RD, 32'h0000_0000, '0, '0, '0);
    queue_item(MODE_REG_WR, 32'h0000_001c, 32'hffff_ffff, '0, '0);  // ignored write
    queue_item(MODE_TICK, '0, '0, '0, 32'd0);                    // idle zero tick
    queue_item(MODE_RAM_WR, 32'h0000_07bf, 32'hdead_beef, '0, '0);
    queue_item(MODE_RAM_WR, 32'h0000_07c0, 32'h0, '0, '0);       // dropped while busy
    queue_item(MODE_RAM_RD, 32'h0000_07bf, '0, 32'h5555_aaaa, '0);  // latch readback
    queue_item(MODE_REG_RD, 32'h0000_0018, '0, '0, '0);
    queue_item(MODE_RAM_RD, 32'h0000_0010, '0, 32'ha5a5_a5a5, '0);
    queue_item(MODE_RAM_WR, 32'hffff_ffff, 32'h0, '0, '0);       // command area
    queue_item(MODE_TICK, '0, '0, '0, 32'd0);                    // zero tick while busy
    queue_item(MODE_TICK, '0, '0, '0, 32'd2149);
    queue_item(MODE_TICK, '0, '0, '0, 32'd1);                    // exact expiry
    queue_item(MODE_REG_WR, 32'h0000_0018, 32'h0, '0, '0);       // clear interrupt
    queue_item(MODE_REG_WR, 32'h0000_0004, 32'hffff_ffff, '0, '0);
    queue_item(MODE_RAM_WR, 32'h0000_0100, 32'h1357_9bdf, '0, '0);
    queue_item(MODE_TICK, '0, '0, '0, 32'd2150);                 // i/o ends, dma still pending
    queue_item(MODE_REG_WR, 32'h0000_0010, 32'h1234_5679, '0, '0);  // restart other way
    queue_item(MODE_TICK, '0, '0, '0, 32'hffff_ffff);            // saturating expiry
    queue_item(MODE_REG_WR, 32'h0000_0004, 32'h0, '0, '0);
    queue_item(MODE_RAM_WR, 32'h0000_0040, 32'hffff_ffff, '0, '0);
    queue_item(MODE_TICK, '0, '0, '0, 32'd14000);                // both timers in one tick
    queue_item(MODE_REG_RD, 32'h0000_0004, '0, '0, '0);
    queue_item(MODE_REG_RD, 32'h0000_0010, '0, '0, '0);
    queue_item(MODE_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(MODE_SPARE_LO, '0, '0, '0, 32'd5);
    wait_idle();

    // random traffic across timing settings
    run_setting(16'd0, 16'd0, 16'd0, 150);
    run_setting(16'hffff, 16'hffff, 16'hffff, 170);
    run_setting(16'd1, 16'd2, 16'd3, 170);
    run_setting(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                16'($urandom_range(1, 64)), 170);
    run_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 170);
    run_setting(16'hffff, 16'd0, 16'd1, 170);

    $display("covered %0d transfers in, %0d results checked, %0d timing settings",
             items_accepted, results_seen, settings_run + 1);
    $display("saw %0d dma completions, %0d i/o completions, %0d command events",
             dma_done_count, io_done_count, cmd_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
design/sidc_pkg.sv
design/sidc_in_stage.sv
design/sidc_ctrl.sv
design/sidc_out_stage.sv
design/serial_interface_dma_controller.sv
design/sidc_checker.sv
tb/sv/serial_interface_dma_controller_test.sv
